// ===== rtl/lfs_pkg.sv =====
// Shared types, widths and constants for the line-follow steering block.
`timescale 1ns / 1ps

package lfs_pkg;

   // Field and register widths
   localparam int LINE_X_W   = 11;
   localparam int SPEED_W    = 8;
   localparam int POS_W      = 8;
   localparam int DB_W       = 7;
   localparam int GAIN_W     = 18;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   // Datapath widths
   localparam int ADJ_W      = LINE_X_W + 1;
   localparam int MUL_A_W    = LINE_X_W + 1;
   localparam int PROD_W     = MUL_A_W + GAIN_W;
   localparam int ACC_W      = PROD_W + 2;
   localparam int Q_FRAC     = 16;
   localparam int WHEEL_W    = ACC_W - Q_FRAC;
   localparam int CLAMP_W    = WHEEL_W + 2;
   localparam int DIVIDEND_W = 15;
   localparam int DIVISOR_W  = 8;
   localparam int PC_W       = 4;
   localparam int LOOP_W     = $clog2(DIVIDEND_W + 1);

   localparam int NORM_MAX = 100;
   localparam int NORM_MIN = -100;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ZERO_POSITION = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SPEED    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEADBAND      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_P_GAIN        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_I_GAIN        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_D_GAIN        = 3'd5;

   typedef struct packed {
      logic signed [POS_W-1:0]   zero_position;
      logic signed [SPEED_W-1:0] base_speed;
      logic        [DB_W-1:0]    deadband;
      logic signed [GAIN_W-1:0]  p_gain;
      logic signed [GAIN_W-1:0]  i_gain;
      logic signed [GAIN_W-1:0]  d_gain;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      zero_position: -8'sd20,
      base_speed:    8'sd60,
      deadband:      7'd10,
      p_gain:        18'sd22938,
      i_gain:        18'sd197,
      d_gain:        -18'sd590
   };

   // Datapath operations, one per control word
   typedef enum logic [3:0] {
      OP_NOP,
      OP_LOAD,
      OP_MUL_P,
      OP_MUL_D,
      OP_MUL_I,
      OP_ACC,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_NORM,
      OP_STEER,
      OP_CLAMP,
      OP_EMIT
   } op_type;

   // Sequencing conditions
   typedef enum logic [1:0] {
      CND_NEXT,
      CND_WAIT_REQ,
      CND_LOOP,
      CND_WAIT_OUT
   } cond_type;

   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic            loop_init;
      logic [PC_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      op_type op;
      logic   req_ready;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic out_busy;
   } status_type;

endpackage

// ===== rtl/lfs_if.sv =====
// Valid/ready channel interfaces for position requests and wheel responses.
`timescale 1ns / 1ps

interface lfs_req_if;
   import lfs_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [LINE_X_W-1:0] line_x;

   modport source (output valid, output line_x, input ready);
   modport sink (input valid, input line_x, output ready);
endinterface

interface lfs_rsp_if;
   import lfs_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [SPEED_W-1:0] left_speed;
   logic signed [SPEED_W-1:0] right_speed;
   logic                      went_straight;

   modport source (output valid, output left_speed, output right_speed,
                   output went_straight, input ready);
   modport sink (input valid, input left_speed, input right_speed,
                 input went_straight, output ready);
endinterface

// ===== rtl/lfs_seq.sv =====
// Microcode sequencer: control store, step counter and loop counter.
`timescale 1ns / 1ps

module lfs_seq (
   input  logic                clock,
   input  logic                reset,
   input  lfs_pkg::status_type status,
   output lfs_pkg::ctrl_type   ctrl
);
   import lfs_pkg::*;

   localparam logic [PC_W-1:0] STEP_IDLE     = 4'd0;
   localparam logic [PC_W-1:0] STEP_MUL_P    = 4'd1;
   localparam logic [PC_W-1:0] STEP_MUL_D    = 4'd2;
   localparam logic [PC_W-1:0] STEP_MUL_I    = 4'd3;
   localparam logic [PC_W-1:0] STEP_ACC      = 4'd4;
   localparam logic [PC_W-1:0] STEP_DIV_INIT = 4'd5;
   localparam logic [PC_W-1:0] STEP_DIV_LOOP = 4'd6;
   localparam logic [PC_W-1:0] STEP_NORM     = 4'd7;
   localparam logic [PC_W-1:0] STEP_STEER    = 4'd8;
   localparam logic [PC_W-1:0] STEP_CLAMP    = 4'd9;
   localparam logic [PC_W-1:0] STEP_EMIT     = 4'd10;

   logic [PC_W-1:0]   pc_ff, pc_in;
   logic [LOOP_W-1:0] loop_ff, loop_in;
   ucode_type         cw;

   function automatic ucode_type uword(input op_type op, input cond_type cond,
                                       input logic loop_init,
                                       input logic [PC_W-1:0] target);
      ucode_type w;
      w.op        = op;
      w.cond      = cond;
      w.loop_init = loop_init;
      w.target    = target;
      return w;
   endfunction

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] addr);
      ucode_type w;
      case (addr)
         STEP_IDLE:     w = uword(OP_LOAD, CND_WAIT_REQ, 1'b0, STEP_IDLE);
         STEP_MUL_P:    w = uword(OP_MUL_P, CND_NEXT, 1'b0, STEP_IDLE);
         STEP_MUL_D:    w = uword(OP_MUL_D, CND_NEXT, 1'b0, STEP_IDLE);
         STEP_MUL_I:    w = uword(OP_MUL_I, CND_NEXT, 1'b0, STEP_IDLE);
         STEP_ACC:      w = uword(OP_ACC, CND_NEXT, 1'b0, STEP_IDLE);
         STEP_DIV_INIT: w = uword(OP_DIV_INIT, CND_NEXT, 1'b1, STEP_IDLE);
         STEP_DIV_LOOP: w = uword(OP_DIV_STEP, CND_LOOP, 1'b0, STEP_IDLE);
         STEP_NORM:     w = uword(OP_NORM, CND_NEXT, 1'b0, STEP_IDLE);
         STEP_STEER:    w = uword(OP_STEER, CND_NEXT, 1'b0, STEP_IDLE);
         STEP_CLAMP:    w = uword(OP_CLAMP, CND_NEXT, 1'b0, STEP_IDLE);
         STEP_EMIT:     w = uword(OP_EMIT, CND_WAIT_OUT, 1'b0, STEP_IDLE);
         default:       w = uword(OP_NOP, CND_WAIT_OUT, 1'b0, STEP_IDLE);
      endcase
      return w;
   endfunction

   assign cw = ucode_rom(pc_ff);

   always_comb begin
      case (cw.cond)
         CND_NEXT:     pc_in = pc_ff + 1'b1;
         CND_WAIT_REQ: pc_in = status.req_valid ? pc_ff + 1'b1 : pc_ff;
         // repeat the step until the last pass
         CND_LOOP:     pc_in = (loop_ff != LOOP_W'(1)) ? pc_ff : pc_ff + 1'b1;
         CND_WAIT_OUT: pc_in = status.out_busy ? pc_ff : cw.target;
         default:      pc_in = cw.target;
      endcase
   end

   always_comb begin
      if (cw.loop_init) begin
         loop_in = LOOP_W'(DIVIDEND_W);
      end else if (cw.cond == CND_LOOP) begin
         loop_in = loop_ff - 1'b1;
      end else begin
         loop_in = loop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= STEP_IDLE;
         loop_ff <= '0;
      end else begin
         pc_ff   <= pc_in;
         loop_ff <= loop_in;
      end
   end

   assign ctrl.op        = cw.op;
   assign ctrl.req_ready = (cw.cond == CND_WAIT_REQ);

endmodule

// ===== rtl/lfs_dp.sv =====
// Steering datapath: multiplier, accumulator, serial divider, clamps, result register.
`timescale 1ns / 1ps

module lfs_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  lfs_pkg::ctrl_type                   ctrl,
   input  lfs_pkg::cfg_type                    cfg,
   input  logic                                req_valid,
   input  logic signed [lfs_pkg::LINE_X_W-1:0] req_line_x,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [lfs_pkg::SPEED_W-1:0]  rsp_left_speed,
   output logic signed [lfs_pkg::SPEED_W-1:0]  rsp_right_speed,
   output logic                                rsp_went_straight,
   output logic                                out_busy
);
   import lfs_pkg::*;

   localparam int SCALED_W = ADJ_W + 7;

   logic signed [LINE_X_W-1:0] x_ff, x_in;
   logic signed [ADJ_W-1:0]    adj_ff, adj_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic [DIVISOR_W-1:0]       rem_ff, rem_in;
   logic [DIVIDEND_W-1:0]      quo_ff, quo_in;
   logic [DIVISOR_W-1:0]       dvs_ff, dvs_in;
   logic signed [POS_W-1:0]    norm_ff, norm_in;
   logic signed [POS_W-1:0]    last_ff, last_in;
   logic signed [WHEEL_W-1:0]  l_ff, l_in;
   logic signed [WHEEL_W-1:0]  r_ff, r_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SPEED_W-1:0]  rsp_left_ff, rsp_left_in;
   logic signed [SPEED_W-1:0]  rsp_right_ff, rsp_right_in;
   logic                       rsp_straight_ff, rsp_straight_in;

   logic signed [MUL_A_W-1:0]  x_ext, prev_ext, x_diff, x_sum, mul_a;
   logic signed [GAIN_W-1:0]   mul_b;
   logic signed [PROD_W-1:0]   mul_p;
   logic [ADJ_W-1:0]           adj_mag;
   logic [SCALED_W-1:0]        scaled;
   logic signed [POS_W:0]      dvs_sub, dvs_add;
   logic [DIVISOR_W:0]         trial, trial_sub;
   logic                       trial_ge;
   logic [POS_W-1:0]           quo_lo;
   logic signed [ACC_W-1:0]    base_q, sum_l, sum_r;
   logic signed [CLAMP_W-1:0]  lw, rw, mx, mn, l_hi, r_hi, l_lo, r_lo;
   logic [LINE_X_W-1:0]        abs_x;
   logic [POS_W-1:0]           abs_prev;
   logic                       straight, emit;

   // Divide by 2^16 with truncation toward zero
   function automatic logic signed [WHEEL_W-1:0] q16_trunc(input logic signed [ACC_W-1:0] v);
      logic signed [WHEEL_W-1:0] hi;
      hi = v[ACC_W-1:Q_FRAC];
      if (v[ACC_W-1] && (v[Q_FRAC-1:0] != '0)) begin
         hi = hi + 1'b1;
      end
      return hi;
   endfunction

   function automatic logic signed [CLAMP_W-1:0] clamp_pct(input logic signed [CLAMP_W-1:0] v);
      logic signed [CLAMP_W-1:0] o;
      if (v > CLAMP_W'(NORM_MAX)) begin
         o = CLAMP_W'(NORM_MAX);
      end else if (v < 0) begin
         o = '0;
      end else begin
         o = v;
      end
      return o;
   endfunction

   assign x_ext    = MUL_A_W'(x_ff);
   assign prev_ext = MUL_A_W'(last_ff);
   assign x_diff   = x_ext - prev_ext;
   assign x_sum    = x_ext + prev_ext;

   always_comb begin
      case (ctrl.op)
         OP_MUL_D: begin
            mul_a = x_diff;
            mul_b = cfg.d_gain;
         end
         OP_MUL_I: begin
            mul_a = x_sum;
            mul_b = cfg.i_gain;
         end
         default: begin
            mul_a = x_ext;
            mul_b = cfg.p_gain;
         end
      endcase
   end

   assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Normalization divisor and dividend
   assign adj_mag = adj_ff[ADJ_W-1] ? ADJ_W'(-adj_ff) : ADJ_W'(adj_ff);
   assign scaled  = SCALED_W'(adj_mag) * SCALED_W'(NORM_MAX);
   assign dvs_sub = (POS_W+1)'(NORM_MAX) - (POS_W+1)'(cfg.zero_position);
   assign dvs_add = (POS_W+1)'(NORM_MAX) + (POS_W+1)'(cfg.zero_position);

   // Restoring divider, one quotient bit per step
   assign trial     = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign trial_ge  = (trial >= {1'b0, dvs_ff});
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign quo_lo    = quo_ff[POS_W-1:0];

   assign base_q = ACC_W'(cfg.base_speed) <<< Q_FRAC;
   assign sum_l  = base_q + acc_ff;
   assign sum_r  = base_q - acc_ff;

   // Over-range shifts use the extremes taken before any adjustment
   assign lw   = CLAMP_W'(l_ff);
   assign rw   = CLAMP_W'(r_ff);
   assign mx   = (lw >= rw) ? lw : rw;
   assign mn   = (lw <= rw) ? lw : rw;
   assign l_hi = (mx > CLAMP_W'(NORM_MAX)) ? clamp_pct(lw - mx + CLAMP_W'(NORM_MAX)) : lw;
   assign r_hi = (mx > CLAMP_W'(NORM_MAX)) ? clamp_pct(rw - mx + CLAMP_W'(NORM_MAX)) : rw;
   assign l_lo = (mn < CLAMP_W'(NORM_MIN)) ? clamp_pct(l_hi - mn + CLAMP_W'(NORM_MIN)) : l_hi;
   assign r_lo = (mn < CLAMP_W'(NORM_MIN)) ? clamp_pct(r_hi - mn + CLAMP_W'(NORM_MIN)) : r_hi;

   assign abs_x    = x_ff[LINE_X_W-1] ? LINE_X_W'(-x_ff) : LINE_X_W'(x_ff);
   assign abs_prev = last_ff[POS_W-1] ? POS_W'(-last_ff) : POS_W'(last_ff);
   assign straight = (abs_x < LINE_X_W'(cfg.deadband)) && (abs_prev < POS_W'(cfg.deadband));

   assign out_busy = rsp_valid_ff && !rsp_ready;
   assign emit     = (ctrl.op == OP_EMIT) && !out_busy;

   always_comb begin
      x_in    = x_ff;
      adj_in  = adj_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      norm_in = norm_ff;
      l_in    = l_ff;
      r_in    = r_ff;
      case (ctrl.op)
         OP_LOAD: begin
            if (req_valid && ctrl.req_ready) begin
               x_in   = req_line_x;
               adj_in = ADJ_W'(req_line_x) - ADJ_W'(cfg.zero_position);
            end
         end
         OP_MUL_P: begin
            prod_in = mul_p;
         end
         OP_MUL_D: begin
            prod_in = mul_p;
            acc_in  = ACC_W'(prod_ff);
         end
         OP_MUL_I: begin
            prod_in = mul_p;
            acc_in  = acc_ff + ACC_W'(prod_ff);
         end
         OP_ACC: begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
         OP_DIV_INIT: begin
            rem_in = '0;
            quo_in = scaled[DIVIDEND_W-1:0];
            dvs_in = adj_ff[ADJ_W-1] ? dvs_add[DIVISOR_W-1:0] : dvs_sub[DIVISOR_W-1:0];
         end
         OP_DIV_STEP: begin
            rem_in = trial_ge ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_in = {quo_ff[DIVIDEND_W-2:0], trial_ge};
         end
         OP_NORM: begin
            if (adj_ff == '0) begin
               norm_in = '0;
            end else if (!adj_ff[ADJ_W-1]) begin
               norm_in = (x_ff >= NORM_MAX) ? POS_W'(NORM_MAX) : quo_lo;
            end else begin
               norm_in = (x_ff <= NORM_MIN) ? POS_W'(NORM_MIN) : -quo_lo;
            end
         end
         OP_STEER: begin
            l_in = q16_trunc(sum_l);
            r_in = q16_trunc(sum_r);
         end
         OP_CLAMP: begin
            l_in = WHEEL_W'(l_lo);
            r_in = WHEEL_W'(r_lo);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      last_in         = last_ff;
      rsp_left_in     = rsp_left_ff;
      rsp_right_in    = rsp_right_ff;
      rsp_straight_in = rsp_straight_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      if (emit) begin
         last_in         = norm_ff;
         rsp_valid_in    = 1'b1;
         rsp_straight_in = straight;
         rsp_left_in     = straight ? cfg.base_speed : l_ff[SPEED_W-1:0];
         rsp_right_in    = straight ? cfg.base_speed : r_ff[SPEED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff            <= x_in;
      adj_ff          <= adj_in;
      prod_ff         <= prod_in;
      acc_ff          <= acc_in;
      rem_ff          <= rem_in;
      quo_ff          <= quo_in;
      dvs_ff          <= dvs_in;
      norm_ff         <= norm_in;
      l_ff            <= l_in;
      r_ff            <= r_in;
      rsp_left_ff     <= rsp_left_in;
      rsp_right_ff    <= rsp_right_in;
      rsp_straight_ff <= rsp_straight_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_speed    = rsp_left_ff;
   assign rsp_right_speed   = rsp_right_ff;
   assign rsp_went_straight = rsp_straight_ff;

endmodule

// ===== rtl/line_follow_steering_step.sv =====
// Line-follow steering step: top level with control registers and the sequencer.
// A request passes the load, multiply, accumulate, divide, normalize, steer, clamp
// and emit steps; the 15-step serial divider loop of the normalization is the
// longest. Positions are handled one at a time; emit waits while the sink is busy.
// A new request is taken while the previous result still waits for its sink.
// Reset (synchronous): control registers return to defaults, last position to 0.
`timescale 1ns / 1ps

module line_follow_steering_step (
   input  logic                                  clock,
   input  logic                                  reset,
   lfs_req_if.sink                               req_if,
   lfs_rsp_if.source                             rsp_if,
   input  logic                                  csr_wr_en,
   input  logic [lfs_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [lfs_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import lfs_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   ctrl_type   ctrl;
   status_type status;
   logic       out_busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_ZERO_POSITION: cfg_in.zero_position = csr_wdata[POS_W-1:0];
            CSR_BASE_SPEED:    cfg_in.base_speed    = csr_wdata[SPEED_W-1:0];
            CSR_DEADBAND:      cfg_in.deadband      = csr_wdata[DB_W-1:0];
            CSR_P_GAIN:        cfg_in.p_gain        = csr_wdata[GAIN_W-1:0];
            CSR_I_GAIN:        cfg_in.i_gain        = csr_wdata[GAIN_W-1:0];
            CSR_D_GAIN:        cfg_in.d_gain        = csr_wdata[GAIN_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign status.req_valid = req_if.valid;
   assign status.out_busy  = out_busy;
   assign req_if.ready     = ctrl.req_ready;

   lfs_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   lfs_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .ctrl              (ctrl),
      .cfg               (cfg_ff),
      .req_valid         (req_if.valid),
      .req_line_x        (req_if.line_x),
      .rsp_ready         (rsp_if.ready),
      .rsp_valid         (rsp_if.valid),
      .rsp_left_speed    (rsp_if.left_speed),
      .rsp_right_speed   (rsp_if.right_speed),
      .rsp_went_straight (rsp_if.went_straight),
      .out_busy          (out_busy)
   );

   // Straight drive puts base speed on both wheels
   a_straight_equal: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.went_straight) |-> (rsp_if.left_speed == rsp_if.right_speed))
      else $error("straight result with unequal wheel speeds");

   // One position in flight: ready drops right after a request transaction
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("request taken while another is in flight");

   // The result register only loads from the emit step
   a_emit_only: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_if.valid)) |-> ($past(ctrl.op) == OP_EMIT))
      else $error("result appeared outside the emit step");

endmodule

// ===== verif/tb_line_follow_steering_step.sv =====
// Self-checking testbench for the line-follow steering step block.
`timescale 1ns / 1ps

module tb_line_follow_steering_step;
   import lfs_pkg::*;

   localparam longint Q16_SCALE = 64'sd1 << Q_FRAC;
   localparam int GAIN_HIGH = 131071;
   localparam int GAIN_LOW = -131072;

   typedef struct {
      logic signed [SPEED_W-1:0] left_speed;
      logic signed [SPEED_W-1:0] right_speed;
      logic went_straight;
   } wheel_cmd_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   lfs_req_if req_ch ();
   lfs_rsp_if rsp_ch ();

   line_follow_steering_step uut (
      .clock(clock),
      .reset(reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Local copy of the control registers and the stored position
   logic signed [POS_W-1:0] cfg_zero = -8'sd20;
   logic signed [SPEED_W-1:0] cfg_base = 8'sd60;
   logic [DB_W-1:0] cfg_deadband = 7'd10;
   logic signed [GAIN_W-1:0] cfg_p = 18'sd22938;
   logic signed [GAIN_W-1:0] cfg_i = 18'sd197;
   logic signed [GAIN_W-1:0] cfg_d = -18'sd590;
   logic signed [POS_W-1:0] last_norm = '0;

   logic signed [LINE_X_W-1:0] pending_x[$];
   wheel_cmd_type expected_wheels[$];
   int queued_count = 0;
   int rsp_count = 0;
   int mismatches = 0;

   int burst_left = 1;
   int gap_left = 0;
   bit drain_hold = 1'b0;
   bit steady_sender = 1'b0;
   bit req_fire = 1'b0;
   int rsp_tick = 0;
   logic [15:0] ready_pattern = 16'hFFFF;

   int default_probes[18] = '{0, -1, 1, 9, -9, -9, -5, -20, 10, -10, 99, 100, 101,
                              -99, -100, -101, -1024, 1023};
   int high_probes[6] = '{1023, -1024, 0, 50, -50, 126};
   int low_probes[4] = '{5, -5, 1023, -1024};

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint limit_percent(input longint v);
      return (v > NORM_MAX) ? NORM_MAX : ((v < 0) ? 0 : v);
   endfunction

   // Work out the wheel command for one position and advance the stored position.
   function automatic wheel_cmd_type steer_wheels(input logic signed [LINE_X_W-1:0] line_x);
      int x, zero, prev, adj, norm, db, mag_x, mag_prev;
      longint acc, base_q, l, r, hi, lo;
      wheel_cmd_type cmd;
      x = line_x;
      zero = cfg_zero;
      prev = last_norm;
      db = cfg_deadband;
      adj = x - zero;
      if (adj > 0) begin
         norm = (x >= NORM_MAX) ? NORM_MAX : (100 * adj) / (NORM_MAX - zero);
      end else if (adj < 0) begin
         norm = (x <= NORM_MIN) ? NORM_MIN : (-100 * adj) / (NORM_MIN - zero);
      end else begin
         norm = 0;
      end
      last_norm = norm[POS_W-1:0];
      mag_x = (x < 0) ? -x : x;
      mag_prev = (prev < 0) ? -prev : prev;
      if (mag_x < db && mag_prev < db) begin
         cmd.left_speed = cfg_base;
         cmd.right_speed = cfg_base;
         cmd.went_straight = 1'b1;
      end else begin
         acc = longint'(x) * cfg_p + longint'(x - prev) * cfg_d
               + longint'(x + prev) * cfg_i;
         base_q = longint'(cfg_base) * Q16_SCALE;
         l = (base_q + acc) / Q16_SCALE;
         r = (base_q - acc) / Q16_SCALE;
         hi = (l >= r) ? l : r;
         lo = (l <= r) ? l : r;
         if (hi > NORM_MAX) begin
            l = limit_percent(l - (hi - NORM_MAX));
            r = limit_percent(r - (hi - NORM_MAX));
         end
         // the raise uses the slower wheel as it was before the drop above
         if (lo < NORM_MIN) begin
            l = limit_percent(l - (lo - NORM_MIN));
            r = limit_percent(r - (lo - NORM_MIN));
         end
         cmd.left_speed = l[SPEED_W-1:0];
         cmd.right_speed = r[SPEED_W-1:0];
         cmd.went_straight = 1'b0;
      end
      return cmd;
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: result %0d: %s", $realtime, rsp_count, what);
      mismatches++;
   endtask

   // Request and result monitor
   always @(posedge clock) begin : channel_monitor
      wheel_cmd_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         rsp_count++;
         if (expected_wheels.size() == 0) begin
            report_mismatch($sformatf("unexpected result left=%0d right=%0d straight=%0b",
                                      rsp_ch.left_speed, rsp_ch.right_speed,
                                      rsp_ch.went_straight));
         end else begin
            want = expected_wheels.pop_front();
            if (rsp_ch.left_speed !== want.left_speed)
               report_mismatch($sformatf("left_speed %0d, want %0d",
                                         rsp_ch.left_speed, want.left_speed));
            if (rsp_ch.right_speed !== want.right_speed)
               report_mismatch($sformatf("right_speed %0d, want %0d",
                                         rsp_ch.right_speed, want.right_speed));
            if (rsp_ch.went_straight !== want.went_straight)
               report_mismatch($sformatf("went_straight %0b, want %0b",
                                         rsp_ch.went_straight, want.went_straight));
         end
      end
      if (!reset && req_ch.valid && req_ch.ready)
         expected_wheels.push_back(steer_wheels(req_ch.line_x));
      req_fire <= !reset && req_ch.valid && req_ch.ready;
   end

   // Position driver: bursts with gaps, an occasional hold until results drain
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (req_ch.valid && !req_fire) begin
         // hold the transaction until the block takes it
      end else if (gap_left > 0) begin
         gap_left--;
         req_ch.valid <= 1'b0;
      end else if (drain_hold && expected_wheels.size() != 0) begin
         req_ch.valid <= 1'b0;
      end else if (pending_x.size() != 0) begin
         drain_hold = 1'b0;
         req_ch.valid <= 1'b1;
         req_ch.line_x <= pending_x.pop_front();
         if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 12);
            gap_left = steady_sender ? 0 : $urandom_range(0, 10);
            drain_hold = !steady_sender && ($urandom_range(0, 19) == 0);
         end else begin
            burst_left--;
         end
      end else begin
         req_ch.valid <= 1'b0;
      end
   end

   // Result sink: ready steps through a 16-bit pattern, reloaded at random and never all zero
   always @(negedge clock) begin
      if (rsp_tick % 64 == 0) begin
         case ($urandom_range(0, 3))
            0: ready_pattern = 16'hFFFF;
            1: ready_pattern = 16'($urandom());
            2: ready_pattern = 16'($urandom() | $urandom());
            default: ready_pattern = 16'($urandom() & $urandom());
         endcase
         if (ready_pattern == '0)
            ready_pattern = 16'h0001;
      end
      rsp_ch.ready <= ready_pattern[rsp_tick[3:0]];
      rsp_tick++;
   end

   task automatic queue_position(input int x);
      pending_x.push_back(x[LINE_X_W-1:0]);
      queued_count++;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_x.size() != 0 || rsp_count != queued_count);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      case (idx)
         CSR_ZERO_POSITION: cfg_zero = value[POS_W-1:0];
         CSR_BASE_SPEED: cfg_base = value[SPEED_W-1:0];
         CSR_DEADBAND: cfg_deadband = value[DB_W-1:0];
         CSR_P_GAIN: cfg_p = value[GAIN_W-1:0];
         CSR_I_GAIN: cfg_i = value[GAIN_W-1:0];
         CSR_D_GAIN: cfg_d = value[GAIN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input int zero, input int base, input int db,
                                 input int p, input int i, input int d);
      write_csr(CSR_ZERO_POSITION, zero);
      write_csr(CSR_BASE_SPEED, base);
      write_csr(CSR_DEADBAND, db);
      write_csr(CSR_P_GAIN, p);
      write_csr(CSR_I_GAIN, i);
      write_csr(CSR_D_GAIN, d);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic int pick_percent(input bit corner);
      if (corner)
         return $urandom_range(0, 1) ? NORM_MAX : NORM_MIN;
      return int'($urandom_range(0, 200)) - 100;
   endfunction

   function automatic int pick_gain(input bit corner);
      if (corner)
         return $urandom_range(0, 1) ? GAIN_HIGH : GAIN_LOW;
      case ($urandom_range(0, 7))
         0: return 0;
         1, 2: return int'($urandom_range(0, 262143)) + GAIN_LOW;
         default: return int'($urandom_range(0, 80000)) - 40000;
      endcase
   endfunction

   // Mostly short tracks of related positions: near centre, slow drift, mid and full range.
   task automatic queue_random_positions(input int count);
      int x, mode, run, db;
      x = 0;
      run = 0;
      repeat (count) begin
         db = cfg_deadband;
         if (run == 0) begin
            mode = $urandom_range(0, 9);
            run = $urandom_range(4, 20);
         end
         run--;
         if (mode < 4) begin
            x = int'($urandom_range(0, 2 * db + 6)) - (db + 3);
         end else if (mode < 6) begin
            x = x + int'($urandom_range(0, 40)) - 20;
            x = (x > 1023) ? 1023 : ((x < -1024) ? -1024 : x);
         end else if (mode < 8) begin
            x = int'($urandom_range(0, 320)) - 160;
         end else begin
            x = int'($urandom_range(0, 2047)) - 1024;
         end
         queue_position(x);
      end
   endtask

   initial begin : stimulus
      int k;
      bit corner_set;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_ch.valid = 1'b0;
      req_ch.line_x = '0;
      rsp_ch.ready = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register defaults, deadband path, saturation edges
      foreach (default_probes[n])
         queue_position(default_probes[n]);
      wait_drained();

      apply_settings(NORM_MAX, NORM_MAX, 127, GAIN_HIGH, GAIN_LOW, GAIN_HIGH);
      foreach (high_probes[n])
         queue_position(high_probes[n]);
      wait_drained();

      apply_settings(NORM_MIN, NORM_MIN, 0, GAIN_LOW, GAIN_HIGH, GAIN_LOW);
      foreach (low_probes[n])
         queue_position(low_probes[n]);
      wait_drained();

      for (k = 0; k < 14; k++) begin
         corner_set = (k % 4 == 3);
         steady_sender = (k % 3 == 1);
         apply_settings(pick_percent(corner_set && ($urandom_range(0, 1) == 1)),
                        pick_percent(corner_set && ($urandom_range(0, 1) == 1)),
                        (corner_set && ($urandom_range(0, 1) == 1))
                           ? ($urandom_range(0, 1) ? 127 : 0) : $urandom_range(0, 40),
                        pick_gain(corner_set && ($urandom_range(0, 1) == 1)),
                        pick_gain(corner_set && ($urandom_range(0, 1) == 1)),
                        pick_gain(corner_set && ($urandom_range(0, 1) == 1)));
         queue_random_positions(130);
         wait_drained();
      end

      repeat (30) @(posedge clock);
      if (expected_wheels.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_wheels.size()));
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/lfs_pkg.sv
rtl/lfs_if.sv
rtl/lfs_seq.sv
rtl/lfs_dp.sv
rtl/line_follow_steering_step.sv
verif/tb_line_follow_steering_step.sv
